/* rtl/svm_pkg.sv */
// shared types, codes, constants and helpers of the sound effect voice mixer
`timescale 1ns / 1ps
package svm_pkg;

   // default sizes of the voice pool and the effect memory
   localparam int DEF_NUM_VOICES   = 8;
   localparam int DEF_NUM_EFFECTS  = 8;
   localparam int DEF_EFFECT_DEPTH = 16384;

   // port field widths
   localparam int MODE_W      = 2;
   localparam int ID_W        = 3;
   localparam int INDEX_W     = 14;
   localparam int SAMPLE_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 15;
   localparam int EFF_COUNT_W = 4;
   localparam int EFF_LEN_W   = 15;

   // item modes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_LENGTH = 1'd1;

   // reset values and saturation limits
   localparam logic [EFF_LEN_W-1:0]       LENGTH_AT_RESET = 15'd12000;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX         = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN         = 16'sh8000;

   // commands from the sequencer to the voice pool
   typedef struct packed {
      logic start;
      logic release_voice;
   } pool_cmd_type;

   // add two samples and clamp to the 16-bit range
   function automatic logic signed [SAMPLE_W-1:0] sat_add(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [SAMPLE_W:0] sum;
      logic signed [SAMPLE_W-1:0] res;
      sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
         res = sum[SAMPLE_W] ? SAT_MIN : SAT_MAX;
      end else begin
         res = sum[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/sound_effect_voice_mixer_top.sv */
// sound effect voice mixer: item sequencer, voice walk and saturating mix
// items: each accepted item is held as a pending result, then moved to the output register
// tick: one voice per cycle through a three-stage
//   read-modify-write walk over the voice memory and the effect memory
// a new item is stalled until the last pending result has moved to the output register
// reset: all voices inactive, effect_count 0, effect_length 12000; memories not cleared
`timescale 1ns / 1ps
module sound_effect_voice_mixer_top #(
   parameter int NUM_VOICES   = svm_pkg::DEF_NUM_VOICES,
   parameter int NUM_EFFECTS  = svm_pkg::DEF_NUM_EFFECTS,
   parameter int EFFECT_DEPTH = svm_pkg::DEF_EFFECT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [svm_pkg::MODE_W-1:0]          req_mode,
   input  logic [svm_pkg::ID_W-1:0]            req_effect_id,
   input  logic [svm_pkg::INDEX_W-1:0]         req_sample_index,
   input  logic signed [svm_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic signed [svm_pkg::SAMPLE_W-1:0] req_base_left,
   input  logic signed [svm_pkg::SAMPLE_W-1:0] req_base_right,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [svm_pkg::SAMPLE_W-1:0] rsp_mixed_left,
   output logic signed [svm_pkg::SAMPLE_W-1:0] rsp_mixed_right,
   output logic [svm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [svm_pkg::COUNT_W-1:0]         rsp_active_voices,
   input  logic                                csr_wr_en,
   input  logic [svm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [svm_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import svm_pkg::*;

   localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW  = $clog2(NUM_VOICES + 1);
   localparam int PW  = $clog2(EFFECT_DEPTH);
   localparam int LW  = $clog2(EFFECT_DEPTH + 1);
   localparam int EW  = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;
   localparam int EAW = EW + PW;
   localparam int VDW = EW + LW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TICK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [EFF_COUNT_W-1:0] effect_count_ff;
   logic [EFF_LEN_W-1:0]   effect_length_ff;

   // pending result
   logic signed [SAMPLE_W-1:0] pend_left_ff, pend_left_in;
   logic signed [SAMPLE_W-1:0] pend_right_ff, pend_right_in;
   logic [STATUS_W-1:0]        pend_status_ff, pend_status_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   // voice walk pipeline
   logic [CW-1:0] issue_cnt_ff, issue_cnt_in;
   logic          a_valid_ff, a_valid_in;
   logic [VW-1:0] a_voice_ff;
   logic          b_valid_ff, b_valid_in;
   logic [VW-1:0] b_voice_ff;
   logic          b_act_ff, b_hit_ff;
   logic [EW-1:0] b_eff_ff;
   logic [LW-1:0] b_pos_ff;

   // decoded request
   logic          req_acc;
   logic [6:0]    id_wide;
   logic [16:0]   idx_wide;
   logic          id_known, idx_known, bad_id;
   logic [EW-1:0] req_eff;

   // memory ports
   logic           eff_we;
   logic [EAW-1:0] eff_waddr, eff_raddr;
   logic [SAMPLE_W-1:0] eff_rdata;
   logic           vm_we;
   logic [VW-1:0]  vm_waddr, vm_raddr;
   logic [VDW-1:0] vm_wdata, vm_rdata;

   // pool
   pool_cmd_type          pool_cmd;
   logic                  free_found;
   logic [VW-1:0]         free_idx;
   logic [NUM_VOICES-1:0] active_vec;
   logic [CW-1:0]         active_count;

   // walk datapath
   logic [16:0]   len_wide;
   logic [LW-1:0] len;
   logic          issue;
   logic [EW-1:0] rd_eff;
   logic [LW-1:0] rd_pos;
   logic          rd_act, rd_hit;
   logic [LW-1:0] pos_next;
   logic          c_release;
   logic          start_go;
   logic          slot_free;

   // request decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign id_wide   = 7'(req_effect_id);
   assign idx_wide  = 17'(req_sample_index);
   assign id_known  = id_wide < 7'(NUM_EFFECTS);
   assign idx_known = idx_wide < 17'(EFFECT_DEPTH);
   assign bad_id    = !id_known || ({1'b0, req_effect_id} >= effect_count_ff);
   assign req_eff   = id_wide[EW-1:0];
   assign start_go  = req_acc && (req_mode == MODE_START) && !bad_id && free_found;

   // played length is capped by the memory depth
   assign len_wide = (17'(effect_length_ff) < 17'(EFFECT_DEPTH)) ?
                     17'(effect_length_ff) : 17'(EFFECT_DEPTH);
   assign len      = LW'(len_wide);

   // effect memory: loads write, the walk reads
   assign eff_we    = req_acc && (req_mode == MODE_LOAD) && id_known && idx_known;
   assign eff_waddr = {req_eff, idx_wide[PW-1:0]};

   svm_ram #(
      .WIDTH  (SAMPLE_W),
      .ADDR_W (EAW)
   ) u_effect_mem (
      .clock   (clock),
      .wr_en   (eff_we),
      .wr_addr (eff_waddr),
      .wr_data (req_sample_value),
      .rd_addr (eff_raddr),
      .rd_data (eff_rdata)
   );

   // voice memory: effect id and position per voice; a start and a walk never overlap,
   // and the walk touches each voice once, so no forwarding is needed
   svm_ram #(
      .WIDTH  (VDW),
      .ADDR_W (VW)
   ) u_voice_mem (
      .clock   (clock),
      .wr_en   (vm_we),
      .wr_addr (vm_waddr),
      .wr_data (vm_wdata),
      .rd_addr (vm_raddr),
      .rd_data (vm_rdata)
   );

   svm_voice_pool #(
      .NUM_VOICES (NUM_VOICES),
      .VW         (VW),
      .CW         (CW)
   ) u_pool (
      .clock        (clock),
      .reset        (reset),
      .cmd          (pool_cmd),
      .release_idx  (b_voice_ff),
      .free_found   (free_found),
      .free_idx     (free_idx),
      .active_vec   (active_vec),
      .active_count (active_count)
   );

   // stage a: issue voice read
   assign issue    = (state_ff == ST_TICK) && (issue_cnt_ff != CW'(NUM_VOICES));
   assign vm_raddr = issue_cnt_ff[VW-1:0];

   // stage b: voice state back, issue sample read
   assign rd_eff    = vm_rdata[VDW-1:LW];
   assign rd_pos    = vm_rdata[LW-1:0];
   assign rd_act    = active_vec[a_voice_ff];
   assign rd_hit    = rd_act && (rd_pos < len);
   assign eff_raddr = {rd_eff, rd_pos[PW-1:0]};

   // stage c: mix, advance, free at end of effect
   assign pos_next  = b_pos_ff + 1'b1;
   assign c_release = b_valid_ff && b_act_ff && (!b_hit_ff || (pos_next >= len));

   assign pool_cmd.start         = start_go;
   assign pool_cmd.release_voice = c_release;

   // voice memory write: start seeds a voice, the walk writes back its position
   assign vm_we    = start_go || (b_valid_ff && b_hit_ff);
   assign vm_waddr = start_go ? free_idx : b_voice_ff;
   assign vm_wdata = start_go ? {req_eff, {LW{1'b0}}} : {b_eff_ff, pos_next};

   assign a_valid_in   = issue;
   assign b_valid_in   = a_valid_ff;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      issue_cnt_in   = issue_cnt_ff;
      pend_left_in   = pend_left_ff;
      pend_right_in  = pend_right_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pend_left_in   = '0;
               pend_right_in  = '0;
               pend_status_in = STATUS_OK;
               state_in       = ST_HOLD;
               unique case (req_mode)
                  MODE_START: begin
                     if (bad_id) begin
                        pend_status_in = STATUS_BAD_ID;
                     end else if (!free_found) begin
                        pend_status_in = STATUS_FULL;
                     end
                  end
                  MODE_TICK: begin
                     pend_left_in  = req_base_left;
                     pend_right_in = req_base_right;
                     issue_cnt_in  = '0;
                     state_in      = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (issue) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (b_valid_ff && b_hit_ff) begin
               pend_left_in  = sat_add(pend_left_ff, eff_rdata);
               pend_right_in = sat_add(pend_right_ff, eff_rdata);
            end
            if (!issue && !a_valid_ff && !b_valid_ff) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_left_in   = pend_left_ff;
               rsp_right_in  = pend_right_ff;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = COUNT_W'(active_count);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         issue_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         issue_cnt_ff <= issue_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_left_ff   <= pend_left_in;
      pend_right_ff  <= pend_right_in;
      pend_status_ff <= pend_status_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_right_ff   <= rsp_right_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      a_voice_ff     <= vm_raddr;
      b_voice_ff     <= a_voice_ff;
      b_act_ff       <= rd_act;
      b_hit_ff       <= rd_hit;
      b_eff_ff       <= rd_eff;
      b_pos_ff       <= rd_pos;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         effect_count_ff  <= '0;
         effect_length_ff <= LENGTH_AT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EFFECT_COUNT:  effect_count_ff  <= csr_wr_data[EFF_COUNT_W-1:0];
            CSR_EFFECT_LENGTH: effect_length_ff <= csr_wr_data[EFF_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mixed_left    = rsp_left_ff;
   assign rsp_mixed_right   = rsp_right_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_active_voices = rsp_count_ff;

   // the walk pipeline only runs during a tick
   a_walk_in_tick: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff || b_valid_ff) |-> (state_ff == ST_TICK))
      else $error("voice walk active outside a tick");

   // a result is released only once the walk has drained
   a_hold_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> (!a_valid_ff && !b_valid_ff && !vm_we))
      else $error("result pending while voice state still changes");

   // a new result comes only from the pending stage
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("result shown without a pending item");

endmodule

/* rtl/svm_ram.sv */
// single-port-write, single-port-read synchronous memory with registered read data
`timescale 1ns / 1ps
module svm_ram #(
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port with registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/svm_voice_pool.sv */
// voice activity flags, first-free voice search and active voice counter
`timescale 1ns / 1ps
module svm_voice_pool #(
   parameter int NUM_VOICES = svm_pkg::DEF_NUM_VOICES,
   parameter int VW         = 3,
   parameter int CW         = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  svm_pkg::pool_cmd_type   cmd,
   input  logic [VW-1:0]           release_idx,
   output logic                    free_found,
   output logic [VW-1:0]           free_idx,
   output logic [NUM_VOICES-1:0]   active_vec,
   output logic [CW-1:0]           active_count
);
   import svm_pkg::*;

   logic [NUM_VOICES-1:0] active_ff, active_in;
   logic [CW-1:0]         count_ff, count_in;

   // lowest inactive slot wins
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (!active_ff[v]) begin
            free_found = 1'b1;
            free_idx   = VW'(v);
         end
      end
   end

   // flag and count updates
   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      if (cmd.start) begin
         active_in[free_idx] = 1'b1;
      end
      if (cmd.release_voice) begin
         active_in[release_idx] = 1'b0;
      end
      if (cmd.start && !cmd.release_voice) begin
         count_in = count_ff + 1'b1;
      end else if (!cmd.start && cmd.release_voice) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   assign active_vec   = active_ff;
   assign active_count = count_ff;

   // counter tracks the flags
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(active_ff)))
      else $error("active voice count out of step with flags");

   // a start is only issued when a slot is free
   a_start_has_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> free_found)
      else $error("voice start with a full pool");

   // only a playing voice is released
   a_release_active: assert property (@(posedge clock) disable iff (reset)
      cmd.release_voice |-> active_ff[release_idx])
      else $error("release of an inactive voice");

endmodule

/* verif/testbench.sv */
// testbench for the voice mixer: directed table and random phases checked against a predictor
`timescale 1ns / 1ps
module testbench;
   import svm_pkg::*;

   localparam int VOICES     = DEF_NUM_VOICES;
   localparam int EFFECTS    = DEF_NUM_EFFECTS;
   localparam int DEPTH      = DEF_EFFECT_DEPTH;
   localparam int MIX_MIN    = -32768;
   localparam int MIX_MAX    = 32767;
   localparam int LONG_HOLD  = 300;
   localparam int PHASES     = 8;
   localparam int PHASE_ITEMS = 225;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // one item on the request channel
   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [ID_W-1:0]            effect_id;
      logic [INDEX_W-1:0]         sample_index;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic signed [SAMPLE_W-1:0] base_left;
      logic signed [SAMPLE_W-1:0] base_right;
   } mix_item_type;

   // one item on the result channel
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_left;
      logic signed [SAMPLE_W-1:0] mixed_right;
      logic [STATUS_W-1:0]        status;
      logic [COUNT_W-1:0]         active_voices;
   } mix_result_type;

   // one row of the directed stimulus: a register write or an item
   typedef struct packed {
      logic                  is_reg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      mix_item_type          item;
      logic                  has_exp;
      mix_result_type        want;
   } plan_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // block inputs, known from time zero
   logic                        req_valid        = 1'b0;
   logic [MODE_W-1:0]           req_mode         = '0;
   logic [ID_W-1:0]             req_effect_id    = '0;
   logic [INDEX_W-1:0]          req_sample_index = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_value = '0;
   logic signed [SAMPLE_W-1:0]  req_base_left    = '0;
   logic signed [SAMPLE_W-1:0]  req_base_right   = '0;
   logic                        rsp_stall        = 1'b0;
   logic                        csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index        = '0;
   logic [CSR_DATA_W-1:0]       csr_wr_data      = '0;

   logic                        req_stall;
   logic                        rsp_valid;
   logic signed [SAMPLE_W-1:0]  rsp_mixed_left;
   logic signed [SAMPLE_W-1:0]  rsp_mixed_right;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_active_voices;

   sound_effect_voice_mixer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_effect_id     (req_effect_id),
      .req_sample_index  (req_sample_index),
      .req_sample_value  (req_sample_value),
      .req_base_left     (req_base_left),
      .req_base_right    (req_base_right),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mixed_left    (rsp_mixed_left),
      .rsp_mixed_right   (rsp_mixed_right),
      .rsp_status        (rsp_status),
      .rsp_active_voices (rsp_active_voices),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // mirror of the block state
   logic signed [SAMPLE_W-1:0] effect_store [0:EFFECTS*DEPTH-1];
   bit                         sample_written [0:EFFECTS*DEPTH-1];
   int unsigned                filled_upto [EFFECTS];
   bit                         voice_on [VOICES];
   int unsigned                voice_fx [VOICES];
   int unsigned                voice_pos [VOICES];
   logic [EFF_COUNT_W-1:0]     eff_count = '0;
   logic [EFF_LEN_W-1:0]       eff_len   = LENGTH_AT_RESET;

   mix_result_type awaited_outputs [$];
   plan_row_type   stim_plan [$];

   int  error_count;
   int  n_items, n_loads, n_starts, n_rejected, n_full, n_ticks, n_clipped, n_reg_writes;
   bit  idle_enable  = 1'b1;
   bit  hold_pending = 1'b0;

   int phase_count [PHASES] = '{8, 3, 15, 0, 8, 5, 2, 8};
   int phase_len   [PHASES] = '{4, 1, 9, 5, 0, 32, 3, 12};

   function automatic int clamp16(input int v);
      if (v < MIX_MIN) return MIX_MIN;
      if (v > MIX_MAX) return MIX_MAX;
      return v;
   endfunction

   // samples actually played: length capped at the memory depth
   function automatic int unsigned play_len();
      return (32'(eff_len) < DEPTH) ? 32'(eff_len) : DEPTH;
   endfunction

   function automatic int unsigned voices_on();
      int unsigned n;
      n = 0;
      for (int v = 0; v < VOICES; v++) if (voice_on[v]) n++;
      return n;
   endfunction

   // expected result of one accepted item, updating the mirrored state
   function automatic mix_result_type predict_mix(input mix_item_type it);
      mix_result_type res;
      int unsigned id, addr, len;
      int          slot, acc_l, acc_r, sum_l, sum_r, smp;
      bit          clipped;
      id = 32'(it.effect_id);
      res = '0;
      res.status = STATUS_OK;
      clipped = 1'b0;
      n_items++;
      case (it.mode)
         MODE_LOAD: begin
            addr = id * DEPTH + 32'(it.sample_index);
            effect_store[addr] = it.sample_value;
            sample_written[addr] = 1'b1;
            while (filled_upto[id] < DEPTH && sample_written[id * DEPTH + filled_upto[id]])
               filled_upto[id]++;
            n_loads++;
         end
         MODE_START: begin
            n_starts++;
            slot = -1;
            for (int v = VOICES - 1; v >= 0; v--) if (!voice_on[v]) slot = v;
            if (id >= 32'(eff_count)) begin
               res.status = STATUS_BAD_ID;
               n_rejected++;
            end else if (slot < 0) begin
               res.status = STATUS_FULL;
               n_full++;
            end else begin
               voice_on[slot]  = 1'b1;
               voice_fx[slot]  = id;
               voice_pos[slot] = 0;
            end
         end
         MODE_TICK: begin
            len = play_len();
            acc_l = 32'(it.base_left);
            acc_r = 32'(it.base_right);
            // voices in slot order, clamping after every add
            for (int v = 0; v < VOICES; v++) begin
               if (voice_on[v]) begin
                  if (voice_pos[v] < len) begin
                     smp = 32'(effect_store[voice_fx[v] * DEPTH + voice_pos[v]]);
                     sum_l = acc_l + smp;
                     sum_r = acc_r + smp;
                     if (sum_l != clamp16(sum_l) || sum_r != clamp16(sum_r)) clipped = 1'b1;
                     acc_l = clamp16(sum_l);
                     acc_r = clamp16(sum_r);
                     voice_pos[v]++;
                  end
                  if (voice_pos[v] >= len) voice_on[v] = 1'b0;
               end
            end
            res.mixed_left  = acc_l[SAMPLE_W-1:0];
            res.mixed_right = acc_r[SAMPLE_W-1:0];
            n_ticks++;
            if (clipped) n_clipped++;
         end
         default: ;
      endcase
      res.active_voices = COUNT_W'(voices_on());
      return res;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 19))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // random item that never plays an effect sample that was not loaded
   function automatic mix_item_type random_item();
      mix_item_type it;
      int unsigned  pick, e, live;
      live = (32'(eff_count) < EFFECTS) ? 32'(eff_count) : EFFECTS;
      it.mode         = MODE_TICK;
      it.effect_id    = ID_W'($urandom);
      it.sample_index = INDEX_W'($urandom);
      it.sample_value = rand_sample();
      it.base_left    = rand_sample();
      it.base_right   = rand_sample();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         it.mode = MODE_LOAD;
         if (live > 0 && $urandom_range(0, 3) != 0) e = $urandom_range(0, live - 1);
         else e = $urandom_range(0, EFFECTS - 1);
         it.effect_id = ID_W'(e);
         if ($urandom_range(0, 3) != 0 && filled_upto[e] < DEPTH)
            it.sample_index = INDEX_W'(filled_upto[e]);
      end else if (pick < 55) begin
         it.mode = MODE_START;
         if (live > 0 && $urandom_range(0, 4) != 0)
            it.effect_id = ID_W'($urandom_range(0, live - 1));
         e = 32'(it.effect_id);
         // a start that would reach unloaded samples becomes the next load of that effect
         if (e < 32'(eff_count) && voices_on() < VOICES && filled_upto[e] < play_len()) begin
            it.mode = MODE_LOAD;
            it.sample_index = INDEX_W'(filled_upto[e]);
         end
      end else if (pick >= 95) begin
         it.mode = MODE_UNUSED;
      end
      return it;
   endfunction

   // offer one item, hold it until accepted, then queue its expected result
   task automatic send_item(input mix_item_type it);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_effect_id    <= it.effect_id;
      req_sample_index <= it.sample_index;
      req_sample_value <= it.sample_value;
      req_base_left    <= it.base_left;
      req_base_right   <= it.base_right;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      awaited_outputs.push_back(predict_mix(it));
   endtask

   task automatic send_tick();
      mix_item_type it;
      it = random_item();
      it.mode = MODE_TICK;
      send_item(it);
   endtask

   // stop offering and wait until every expected result has come
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_EFFECT_COUNT) eff_count = EFF_COUNT_W'(value);
      else eff_len = EFF_LEN_W'(value);
      n_reg_writes++;
   endtask

   // load effect samples in order until the first upto are written
   task automatic fill_effect(input int unsigned e, input int unsigned upto);
      mix_item_type it;
      while (filled_upto[e] < upto) begin
         it = random_item();
         it.mode = MODE_LOAD;
         it.effect_id = ID_W'(e);
         it.sample_index = INDEX_W'(filled_upto[e]);
         send_item(it);
      end
   endtask

   // voices still playing must have their samples loaded up to the new length
   task automatic set_length(input int unsigned len);
      for (int v = 0; v < VOICES; v++)
         if (voice_on[v]) fill_effect(voice_fx[v], (len < DEPTH) ? len : DEPTH);
      write_reg(CSR_EFFECT_LENGTH, len);
   endtask

   function automatic void plan_item(input logic [MODE_W-1:0] mode, input int id, idx, val,
                                     input int bl, br);
      plan_row_type row;
      row = '0;
      row.item.mode         = mode;
      row.item.effect_id    = ID_W'(id);
      row.item.sample_index = INDEX_W'(idx);
      row.item.sample_value = SAMPLE_W'(val);
      row.item.base_left    = SAMPLE_W'(bl);
      row.item.base_right   = SAMPLE_W'(br);
      stim_plan.push_back(row);
   endfunction

   // attach a typed expectation to the last planned item
   function automatic void plan_result(input int l, r, input logic [STATUS_W-1:0] st,
                                       input int act);
      plan_row_type row;
      row = stim_plan.pop_back();
      row.has_exp = 1'b1;
      row.want.mixed_left    = SAMPLE_W'(l);
      row.want.mixed_right   = SAMPLE_W'(r);
      row.want.status        = st;
      row.want.active_voices = COUNT_W'(act);
      stim_plan.push_back(row);
   endfunction

   function automatic void plan_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      plan_row_type row;
      row = '0;
      row.is_reg   = 1'b1;
      row.reg_idx  = idx;
      row.reg_data = CSR_DATA_W'(data);
      stim_plan.push_back(row);
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want, got);
      if (got !== want) begin
         error_count++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      forever begin
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_pending = 1'b0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      mix_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_outputs.size() == 0) begin
            error_count++;
            $error("result with no expectation waiting");
         end else begin
            want = awaited_outputs.pop_front();
            check_field("mixed_left", 32'(want.mixed_left), 32'(rsp_mixed_left));
            check_field("mixed_right", 32'(want.mixed_right), 32'(rsp_mixed_right));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("active_voices", 32'(want.active_voices), 32'(rsp_active_voices));
         end
      end
   end

   // run limit
   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      for (int e = 0; e < EFFECTS; e++) filled_upto[e] = 0;
      for (int v = 0; v < VOICES; v++) begin
         voice_on[v]  = 1'b0;
         voice_fx[v]  = 0;
         voice_pos[v] = 0;
      end

      // directed: empty pool, rejects, unused mode, top corner load
      plan_item(MODE_TICK, 0, 0, 0, 32767, -32768);   plan_result(32767, -32768, STATUS_OK, 0);
      plan_item(MODE_START, 0, 0, 0, 0, 0);           plan_result(0, 0, STATUS_BAD_ID, 0);
      plan_item(MODE_UNUSED, 7, 16383, -1, -1, -1);   plan_result(0, 0, STATUS_OK, 0);
      plan_item(MODE_LOAD, 7, 16383, -32768, 5, 5);   plan_result(0, 0, STATUS_OK, 0);
      plan_reg(CSR_EFFECT_COUNT, 2);
      plan_reg(CSR_EFFECT_LENGTH, 2);
      plan_item(MODE_LOAD, 0, 0, 32767, 0, 0);        plan_result(0, 0, STATUS_OK, 0);
      plan_item(MODE_LOAD, 0, 1, -32768, 0, 0);       plan_result(0, 0, STATUS_OK, 0);
      plan_item(MODE_LOAD, 1, 0, 32767, 0, 0);        plan_result(0, 0, STATUS_OK, 0);
      plan_item(MODE_LOAD, 1, 1, -1, 0, 0);           plan_result(0, 0, STATUS_OK, 0);
      plan_item(MODE_START, 2, 0, 0, 0, 0);           plan_result(0, 0, STATUS_BAD_ID, 0);
      plan_item(MODE_START, 7, 0, 0, 0, 0);           plan_result(0, 0, STATUS_BAD_ID, 0);
      plan_item(MODE_START, 0, 0, 0, 0, 0);           plan_result(0, 0, STATUS_OK, 1);
      plan_item(MODE_START, 1, 0, 0, 0, 0);           plan_result(0, 0, STATUS_OK, 2);
      // saturation both ways, then both voices run out
      plan_item(MODE_TICK, 0, 0, 0, 32767, -32768);
      plan_item(MODE_TICK, 0, 0, 0, 0, 0);
      // zero length: fill the pool, overflow it, one tick frees everything
      plan_reg(CSR_EFFECT_LENGTH, 0);
      for (int k = 1; k <= VOICES; k++) begin
         plan_item(MODE_START, 0, 0, 0, 0, 0);
         plan_result(0, 0, STATUS_OK, k);
      end
      plan_item(MODE_START, 1, 0, 0, 0, 0);           plan_result(0, 0, STATUS_FULL, VOICES);
      plan_item(MODE_TICK, 0, 0, 0, -32768, 32767);   plan_result(-32768, 32767, STATUS_OK, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_plan[i]) begin
         if (stim_plan[i].is_reg) begin
            write_reg(stim_plan[i].reg_idx, 32'(stim_plan[i].reg_data));
         end else begin
            send_item(stim_plan[i].item);
            if (stim_plan[i].has_exp) awaited_outputs[$] = stim_plan[i].want;
         end
      end

      // random phases over several register settings
      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_EFFECT_COUNT, phase_count[p]);
         set_length(phase_len[p]);
         idle_enable = (p != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p % 5 == 0 && n == PHASE_ITEMS / 3) hold_pending = 1'b1;
            if (n == 2 * PHASE_ITEMS / 3 || $urandom_range(0, 99) == 0) wait_idle();
            send_item(random_item());
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("run covered %0d items: %0d loads, %0d starts (%0d bad id, %0d pool full)",
               n_items, n_loads, n_starts, n_rejected, n_full);
      $display("%0d mixed frames (%0d clipped), %0d register writes",
               n_ticks, n_clipped, n_reg_writes);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
rtl/svm_pkg.sv
rtl/svm_ram.sv
rtl/svm_voice_pool.sv
rtl/sound_effect_voice_mixer_top.sv
verif/testbench.sv
